FILE: src/complex_arith_unit_defines.svh
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CAU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAU_ASSERT(lbl, prop, msg)
`define CAU_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: src/cau_pkg.sv
package cau_pkg;

  localparam int DIV_STEPS = 32;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_EQ  = 3'd4;
  localparam logic [2:0] MODE_NE  = 3'd5;

  localparam logic signed [48:0] QMAX49 = 49'sd2147483647;
  localparam logic signed [48:0] QMIN49 = -49'sd2147483648;
  localparam logic signed [48:0] BIG49  = 49'sd1099511627776;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] a_re;
    logic [31:0] a_im;
    logic [31:0] b_re;
    logic [31:0] b_im;
  } cau_op_t;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        cmp;
    logic        dz;
    logic        sat;
  } cau_res_t;

  typedef struct packed {
    logic [31:0] v;
    logic        s;
  } cau_clamp_t;

  typedef struct packed {
    logic [63:0] den;
    logic [63:0] rem_re;
    logic [63:0] rem_im;
    logic [31:0] sh_re;
    logic [31:0] sh_im;
    logic        neg_re;
    logic        neg_im;
    logic        ovf_re;
    logic        ovf_im;
    logic        is_div;
    cau_res_t    early;
  } cau_div_t;

  function automatic logic signed [48:0] sx49(input logic [31:0] v);
    return $signed({{17{v[31]}}, v});
  endfunction

  function automatic cau_clamp_t clamp_q(input logic signed [48:0] x);
    cau_clamp_t r;
    if (x > QMAX49) begin
      r.v = 32'h7FFF_FFFF;
      r.s = 1'b1;
    end else if (x < QMIN49) begin
      r.v = 32'h8000_0000;
      r.s = 1'b1;
    end else begin
      r.v = x[31:0];
      r.s = 1'b0;
    end
    return r;
  endfunction

  // one restoring step per lane: remainder shifts in the next dividend bit,
  // quotient bit enters at the bottom of the same shift word
  function automatic cau_div_t div_step(input cau_div_t x);
    logic [64:0] d65;
    logic [64:0] t_re;
    logic [64:0] t_im;
    cau_div_t    r;
    r    = x;
    d65  = {1'b0, x.den};
    t_re = {x.rem_re, x.sh_re[31]};
    t_im = {x.rem_im, x.sh_im[31]};
    if (t_re >= d65) begin
      t_re    = t_re - d65;
      r.sh_re = {x.sh_re[30:0], 1'b1};
    end else begin
      r.sh_re = {x.sh_re[30:0], 1'b0};
    end
    if (t_im >= d65) begin
      t_im    = t_im - d65;
      r.sh_im = {x.sh_im[30:0], 1'b1};
    end else begin
      r.sh_im = {x.sh_im[30:0], 1'b0};
    end
    r.rem_re = t_re[63:0];
    r.rem_im = t_im[63:0];
    return r;
  endfunction

  function automatic cau_clamp_t quo_clamp(input logic [31:0] q, input logic neg,
                                           input logic ovf);
    logic signed [48:0] m;
    m = ovf ? BIG49 : $signed({17'b0, q});
    return clamp_q(neg ? -m : m);
  endfunction

endpackage

FILE: src/cau_front.sv
module cau_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  cau_pkg::cau_op_t   in_op,
  output logic               in_rdy,
  output logic               out_vld,
  output cau_pkg::cau_div_t  out_data,
  input  logic               out_rdy
);

  typedef struct packed {
    logic [2:0]       mode;
    logic [63:0]      p_ac;
    logic [63:0]      p_bd;
    logic [63:0]      p_ad;
    logic [63:0]      p_bc;
    logic [63:0]      p_cc;
    logic [63:0]      p_dd;
    cau_pkg::cau_res_t early;
  } cau_prod_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic [64:0]      sum_re;
    logic [64:0]      sum_im;
    logic [63:0]      den;
    cau_pkg::cau_res_t early;
  } cau_sum_t;

  logic [3:0]        vld;
  logic [4:0]        adv;
  cau_pkg::cau_op_t  op;
  cau_prod_t         prod;
  cau_prod_t         prod_next;
  cau_sum_t          sum;
  cau_sum_t          sum_next;
  cau_pkg::cau_div_t setup;
  cau_pkg::cau_div_t setup_next;

  always_comb begin
    adv[4] = out_rdy;
    for (int k = 3; k >= 0; k--) adv[k] = !vld[k] || adv[k+1];
  end
  assign in_rdy   = adv[0];
  assign out_vld  = vld[3];
  assign out_data = setup;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_vld;
      for (int k = 1; k < 4; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) op <= in_op;
    if (adv[1]) prod <= prod_next;
    if (adv[2]) sum <= sum_next;
    if (adv[3]) setup <= setup_next;
  end

  // products and the modes that need none
  always_comb begin
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic signed [31:0] sc;
    logic signed [31:0] sd;
    logic signed [63:0] t;
    cau_pkg::cau_clamp_t cr;
    cau_pkg::cau_clamp_t ci;
    cr = '0;
    ci = '0;
    sa = $signed(op.a_re);
    sb = $signed(op.a_im);
    sc = $signed(op.b_re);
    sd = $signed(op.b_im);
    prod_next.mode = op.mode;
    t = sa * sc; prod_next.p_ac = t;
    t = sb * sd; prod_next.p_bd = t;
    t = sa * sd; prod_next.p_ad = t;
    t = sb * sc; prod_next.p_bc = t;
    t = sc * sc; prod_next.p_cc = t;
    t = sd * sd; prod_next.p_dd = t;
    prod_next.early = '0;
    unique case (op.mode)
      cau_pkg::MODE_ADD: begin
        cr = cau_pkg::clamp_q(cau_pkg::sx49(op.a_re) + cau_pkg::sx49(op.b_re));
        ci = cau_pkg::clamp_q(cau_pkg::sx49(op.a_im) + cau_pkg::sx49(op.b_im));
        prod_next.early = '{re: cr.v, im: ci.v, cmp: 1'b0, dz: 1'b0, sat: cr.s | ci.s};
      end
      cau_pkg::MODE_SUB: begin
        cr = cau_pkg::clamp_q(cau_pkg::sx49(op.a_re) - cau_pkg::sx49(op.b_re));
        ci = cau_pkg::clamp_q(cau_pkg::sx49(op.a_im) - cau_pkg::sx49(op.b_im));
        prod_next.early = '{re: cr.v, im: ci.v, cmp: 1'b0, dz: 1'b0, sat: cr.s | ci.s};
      end
      cau_pkg::MODE_EQ:
        prod_next.early.cmp = (op.a_re == op.b_re) && (op.a_im == op.b_im);
      cau_pkg::MODE_NE:
        prod_next.early.cmp = (op.a_re != op.b_re) || (op.a_im != op.b_im);
      default: prod_next.early = '0;
    endcase
  end

  always_comb begin
    logic signed [64:0] ac;
    logic signed [64:0] bd;
    logic signed [64:0] ad;
    logic signed [64:0] bc;
    ac = $signed({prod.p_ac[63], prod.p_ac});
    bd = $signed({prod.p_bd[63], prod.p_bd});
    ad = $signed({prod.p_ad[63], prod.p_ad});
    bc = $signed({prod.p_bc[63], prod.p_bc});
    sum_next.mode  = prod.mode;
    sum_next.early = prod.early;
    sum_next.den   = prod.p_cc + prod.p_dd;
    if (prod.mode == cau_pkg::MODE_MUL) begin
      sum_next.sum_re = ac - bd;
      sum_next.sum_im = ad + bc;
    end else begin
      sum_next.sum_re = ac + bd;
      sum_next.sum_im = bc - ad;
    end
  end

  // divider setup; multiply finishes here with a floor shift
  always_comb begin
    logic [64:0] neg_re;
    logic [64:0] neg_im;
    logic [63:0] mag_re;
    logic [63:0] mag_im;
    cau_pkg::cau_clamp_t cr;
    cau_pkg::cau_clamp_t ci;
    neg_re = -sum.sum_re;
    neg_im = -sum.sum_im;
    mag_re = sum.sum_re[64] ? neg_re[63:0] : sum.sum_re[63:0];
    mag_im = sum.sum_im[64] ? neg_im[63:0] : sum.sum_im[63:0];
    setup_next.den    = sum.den;
    setup_next.neg_re = sum.sum_re[64];
    setup_next.neg_im = sum.sum_im[64];
    setup_next.ovf_re = {16'b0, mag_re} >= {sum.den, 16'b0};
    setup_next.ovf_im = {16'b0, mag_im} >= {sum.den, 16'b0};
    setup_next.rem_re = {16'b0, mag_re[63:16]};
    setup_next.rem_im = {16'b0, mag_im[63:16]};
    setup_next.sh_re  = {mag_re[15:0], 16'b0};
    setup_next.sh_im  = {mag_im[15:0], 16'b0};
    setup_next.is_div = (sum.mode == cau_pkg::MODE_DIV) && (sum.den != 64'd0);
    cr = cau_pkg::clamp_q($signed(sum.sum_re[64:16]));
    ci = cau_pkg::clamp_q($signed(sum.sum_im[64:16]));
    priority if (sum.mode == cau_pkg::MODE_MUL) begin
      setup_next.early = '{re: cr.v, im: ci.v, cmp: 1'b0, dz: 1'b0, sat: cr.s | ci.s};
    end else if (sum.mode == cau_pkg::MODE_DIV && sum.den == 64'd0) begin
      setup_next.early    = '0;
      setup_next.early.dz = 1'b1;
    end else begin
      setup_next.early = sum.early;
    end
  end

endmodule

FILE: src/cau_div_stage.sv
module cau_div_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  cau_pkg::cau_div_t  in_data,
  output logic               in_rdy,
  output logic               out_vld,
  output cau_pkg::cau_div_t  out_data,
  input  logic               out_rdy
);

  logic              vld;
  cau_pkg::cau_div_t data;

  assign in_rdy   = !vld || out_rdy;
  assign out_vld  = vld;
  assign out_data = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_rdy) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) data <= cau_pkg::div_step(in_data);
  end

endmodule

FILE: src/cau_back.sv
module cau_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  cau_pkg::cau_div_t  in_data,
  output logic               in_rdy,
  output logic               out_vld,
  output cau_pkg::cau_res_t  out_data,
  input  logic               out_rdy
);

  logic              vld;
  cau_pkg::cau_res_t res;
  cau_pkg::cau_res_t res_next;

  assign in_rdy   = !vld || out_rdy;
  assign out_vld  = vld;
  assign out_data = res;

  always_comb begin
    cau_pkg::cau_clamp_t cr;
    cau_pkg::cau_clamp_t ci;
    cr = cau_pkg::quo_clamp(in_data.sh_re, in_data.neg_re, in_data.ovf_re);
    ci = cau_pkg::quo_clamp(in_data.sh_im, in_data.neg_im, in_data.ovf_im);
    if (in_data.is_div) begin
      res_next = '{re: cr.v, im: ci.v, cmp: 1'b0, dz: 1'b0, sat: cr.s | ci.s};
    end else begin
      res_next = in_data.early;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_rdy) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) res <= res_next;
  end

endmodule

FILE: src/complex_arith_unit.sv
// Complex-number ALU on signed Q16.16 operands.
// Slave stream: s_tuser carries the mode (add, sub, mul, div, eq, ne),
// s_tdata the operands a and b. Master stream: m_tdata carries the result,
// m_tuser the compare, divide-by-zero and saturation flags.
// Every transaction in gives exactly one transaction out, in order.
// Throughput: one transaction per cycle, every mode, while the output is not stalled.
// Register stages, 37 in all, passed in order before m_tvalid rises:
// four front stages (input, products, sums, divider setup),
// 32 divider stages at one quotient bit each, and the output register.
// Non-divide modes ride the same stages.
// Each stage holds when it is full and the stage ahead cannot take it,
// so empty slots close up while m_tready is low; s_tready drops only
// once every stage is full. Nothing is lost or repeated on a stall.
// Reset (rst, synchronous) empties the pipeline; m_tvalid goes low.
`include "complex_arith_unit_defines.svh"

module complex_arith_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // a_re, a_im, b_re, b_im
  input  logic [2:0]   s_tuser,  // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,  // res_re, res_im
  output logic [2:0]   m_tuser   // compare_true, div_by_zero, saturated
);

  cau_pkg::cau_op_t  op;
  cau_pkg::cau_div_t lane_data [cau_pkg::DIV_STEPS+1];
  logic              lane_vld  [cau_pkg::DIV_STEPS+1];
  logic              lane_rdy  [cau_pkg::DIV_STEPS+1];
  cau_pkg::cau_res_t res;

  assign op = '{mode: s_tuser, a_re: s_tdata[31:0], a_im: s_tdata[63:32],
                b_re: s_tdata[95:64], b_im: s_tdata[127:96]};

  cau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (s_tvalid),
    .in_op    (op),
    .in_rdy   (s_tready),
    .out_vld  (lane_vld[0]),
    .out_data (lane_data[0]),
    .out_rdy  (lane_rdy[0])
  );

  for (genvar i = 0; i < cau_pkg::DIV_STEPS; i++) begin : g_div
    cau_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (lane_vld[i]),
      .in_data  (lane_data[i]),
      .in_rdy   (lane_rdy[i]),
      .out_vld  (lane_vld[i+1]),
      .out_data (lane_data[i+1]),
      .out_rdy  (lane_rdy[i+1])
    );
  end

  cau_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (lane_vld[cau_pkg::DIV_STEPS]),
    .in_data  (lane_data[cau_pkg::DIV_STEPS]),
    .in_rdy   (lane_rdy[cau_pkg::DIV_STEPS]),
    .out_vld  (m_tvalid),
    .out_data (res),
    .out_rdy  (m_tready)
  );

  assign m_tdata = {res.im, res.re};
  assign m_tuser = {res.sat, res.dz, res.cmp};

  `CAU_ASSERT(a_dz_clean, m_tvalid && m_tuser[1] |-> m_tdata == '0 && m_tuser == 3'b010, "dz")
  `CAU_ASSERT(a_cmp_clean, m_tvalid && m_tuser[0] |-> m_tdata == '0 && m_tuser == 3'b001, "cmp")
  `CAU_ASSERT(a_ready_flow, m_tready |-> s_tready, "pipeline blocked with sink ready")
  `CAU_ASSERT_RST(a_rst_empty, rst |=> !m_tvalid, "output valid after reset")

endmodule
